FILE: rtl/core/cuckoo_filter_insert_lookup_defines.svh
// assertion helpers for the cuckoo filter rtl
`ifndef CUCKOO_FILTER_INSERT_LOOKUP_DEFINES_SVH
`define CUCKOO_FILTER_INSERT_LOOKUP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CFL_ASSERT_IMP(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CFL_ASSERT_NXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/cfl_pkg.sv
`timescale 1ns / 1ps

package cfl_pkg;

    // default geometry
    localparam int NUM_BUCKETS_DEF      = 1024;
    localparam int SLOTS_PER_BUCKET_DEF = 4;
    localparam int FP_BITS_DEF          = 7;

    // register and field widths
    localparam int KICKS_W    = 9;
    localparam int BBITS_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MIX_W      = 16;
    localparam int LFSR_W     = 16;

    // register reset values
    localparam logic [KICKS_W-1:0] MAX_KICKS_RESET   = 9'd500;
    localparam logic [BBITS_W-1:0] BUCKET_BITS_RESET = 4'd10;
    localparam logic [LFSR_W-1:0]  LFSR_SEED         = 16'hACE1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_KICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_BITS = 2'd1;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // fingerprint mixing constant
    localparam logic [31:0] MIX_MULT = 32'h9E3779B1;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [STATUS_W-1:0] {
        STS_ABSENT  = 2'd0,
        STS_PRESENT = 2'd1,
        STS_STORED  = 2'd2,
        STS_FAILED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_LOOKUP      = 2'd0,
        KIND_INSERT      = 2'd1,
        KIND_ZERO_LOOKUP = 2'd2,
        KIND_ZERO_INSERT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        BK_CLEAR = 3'd0,
        BK_IDLE  = 3'd1,
        BK_EVAL  = 3'd2,
        BK_ADV   = 3'd3,
        BK_SEL   = 3'd4,
        BK_KICK  = 3'd5,
        BK_ALT   = 3'd6,
        BK_PLACE = 3'd7
    } back_state_t;

    // upper half of fingerprint times the golden-ratio constant
    function automatic logic [MIX_W-1:0] fp_mix(input logic [MIX_W-1:0] f);
        logic [31:0] h;
        h = 32'(f) * MIX_MULT;
        return h[31:16];
    endfunction

    // keep the low bucket_bits bits of an index
    function automatic logic [MIX_W-1:0] bucket_mask(input logic [MIX_W-1:0] x,
                                                     input logic [BBITS_W-1:0] bb);
        logic [MIX_W:0] m;
        m = ((MIX_W+1)'(1) << bb) - (MIX_W+1)'(1);
        return x & m[MIX_W-1:0];
    endfunction

    // right-shifting fibonacci lfsr, taps 16 14 13 11
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        logic fb;
        fb = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {fb, l[LFSR_W-1:1]};
    endfunction

endpackage

FILE: rtl/core/cuckoo_filter_insert_lookup.sv
`timescale 1ns / 1ps
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-----------------------------------
// s_        | in        | s_valid / s_ready   | s_opcode, s_fingerprint, s_bucket_index
// m_        | out       | m_valid / m_ready   | m_status, m_kicks_used
// cfg_      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// lookups and inserts that find a free slot take a bucket read, then an evaluate step,
// in the back end; each eviction adds an lfsr step, a slot pick, a swap write, an
// alternate bucket read and a place.
// after reset a clearing pass writes every bucket row with s_ready low.
// a two-beat queue separates the front from the back; a stalled m_ channel
// holds the back end while the front keeps accepting until the queue fills.
// NUM_BUCKETS must be a power of two.

module cuckoo_filter_insert_lookup #(
    parameter int NUM_BUCKETS      = cfl_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = cfl_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int FP_BITS          = cfl_pkg::FP_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [FP_BITS-1:0]                s_fingerprint,
    input  logic [$clog2(NUM_BUCKETS)-1:0]    s_bucket_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cfl_pkg::STATUS_W-1:0]      m_status,
    output logic [cfl_pkg::KICKS_W-1:0]       m_kicks_used,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int ITEM_W = 2 + FP_BITS + 2 * BW;

    logic [cfl_pkg::KICKS_W-1:0] max_kicks_reg, max_kicks_next;
    logic [cfl_pkg::BBITS_W-1:0] bucket_bits_reg, bucket_bits_next;
    logic                        clearing;
    logic                        push_valid;
    logic                        push_ready;
    logic [ITEM_W-1:0]           push_item;
    logic                        q_valid;
    logic                        q_pop;
    logic [ITEM_W-1:0]           q_item;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        max_kicks_next   = max_kicks_reg;
        bucket_bits_next = bucket_bits_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cfl_pkg::CFG_MAX_KICKS: begin
                    max_kicks_next = cfg_data[cfl_pkg::KICKS_W-1:0];
                end
                cfl_pkg::CFG_BUCKET_BITS: begin
                    bucket_bits_next = cfg_data[cfl_pkg::BBITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_kicks_reg   <= cfl_pkg::MAX_KICKS_RESET;
            bucket_bits_reg <= cfl_pkg::BUCKET_BITS_RESET;
        end else begin
            max_kicks_reg   <= max_kicks_next;
            bucket_bits_reg <= bucket_bits_next;
        end
    end

    // front: accept, classify, hash to buckets
    cfl_front #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .FP_BITS     (FP_BITS)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_fingerprint  (s_fingerprint),
        .s_bucket_index (s_bucket_index),
        .bucket_bits    (bucket_bits_reg),
        .clearing       (clearing),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // queue between front and back
    cfl_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_item   (q_item)
    );

    // back: table access, eviction walk, result
    cfl_back #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .FP_BITS          (FP_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .max_kicks    (max_kicks_reg),
        .bucket_bits  (bucket_bits_reg),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_kicks_used (m_kicks_used)
    );

endmodule

FILE: rtl/core/cfl_ram.sv
`timescale 1ns / 1ps

module cfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports, data held until the next read
    always_ff @(posedge aclk) begin
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/core/cfl_queue.sv
`timescale 1ns / 1ps

module cfl_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_item
);

    localparam int DEPTH = cfl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/cfl_front.sv
`timescale 1ns / 1ps

module cfl_front #(
    parameter int NUM_BUCKETS = cfl_pkg::NUM_BUCKETS_DEF,
    parameter int FP_BITS     = cfl_pkg::FP_BITS_DEF
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [FP_BITS-1:0]                s_fingerprint,
    input  logic [$clog2(NUM_BUCKETS)-1:0]    s_bucket_index,
    input  logic [cfl_pkg::BBITS_W-1:0]       bucket_bits,
    input  logic                              clearing,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [2+FP_BITS+2*$clog2(NUM_BUCKETS)-1:0] push_item
);

    localparam int BW = $clog2(NUM_BUCKETS);

    cfl_pkg::kind_t              kind;
    logic [cfl_pkg::MIX_W-1:0]   primary_full;
    logic [cfl_pkg::MIX_W-1:0]   alt_full;
    logic [BW-1:0]               primary;
    logic [BW-1:0]               alternate;

    // no beats while the table is being cleared
    assign s_ready    = push_ready && !clearing;
    assign push_valid = s_valid && !clearing;

    // classify the beat
    always_comb begin
        if (s_fingerprint == '0) begin
            kind = (s_opcode == cfl_pkg::OP_LOOKUP) ? cfl_pkg::KIND_ZERO_LOOKUP
                                                    : cfl_pkg::KIND_ZERO_INSERT;
        end else begin
            kind = (s_opcode == cfl_pkg::OP_LOOKUP) ? cfl_pkg::KIND_LOOKUP
                                                    : cfl_pkg::KIND_INSERT;
        end
    end

    // primary and alternate bucket
    always_comb begin
        primary_full = cfl_pkg::bucket_mask(cfl_pkg::MIX_W'(s_bucket_index), bucket_bits);
        alt_full     = cfl_pkg::bucket_mask(
                           primary_full ^ cfl_pkg::fp_mix(cfl_pkg::MIX_W'(s_fingerprint)),
                           bucket_bits);
        primary      = primary_full[BW-1:0];
        alternate    = alt_full[BW-1:0];
    end

    assign push_item = {kind, s_fingerprint, primary, alternate};

endmodule

FILE: rtl/core/cfl_back.sv
`timescale 1ns / 1ps
`include "cuckoo_filter_insert_lookup_defines.svh"

module cfl_back #(
    parameter int NUM_BUCKETS      = cfl_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = cfl_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int FP_BITS          = cfl_pkg::FP_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  logic [2+FP_BITS+2*$clog2(NUM_BUCKETS)-1:0] q_item,
    input  logic [cfl_pkg::KICKS_W-1:0]                max_kicks,
    input  logic [cfl_pkg::BBITS_W-1:0]                bucket_bits,
    output logic                                       clearing,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [cfl_pkg::STATUS_W-1:0]               m_status,
    output logic [cfl_pkg::KICKS_W-1:0]                m_kicks_used
);

    localparam int BW      = $clog2(NUM_BUCKETS);
    localparam int ITEM_W  = 2 + FP_BITS + 2 * BW;
    localparam int ROW_W   = SLOTS_PER_BUCKET * FP_BITS;
    localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CAND_W  = 2 * SLOTS_PER_BUCKET;
    localparam int X_W     = cfl_pkg::LFSR_W - 1;
    // reciprocal of the slot count, exact for every 15-bit dividend
    localparam int RECIP_SH = X_W + 4;
    localparam int RECIP    = ((1 << RECIP_SH) + SLOTS_PER_BUCKET - 1) / SLOTS_PER_BUCKET;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = X_W + RECIP_W;
    localparam int DIFF_W   = X_W + 4;

    cfl_pkg::back_state_t         state_reg, state_next;
    logic [BW-1:0]                clr_cnt_reg, clr_cnt_next;
    cfl_pkg::kind_t               kind_reg, kind_next;
    logic [FP_BITS-1:0]           carry_reg, carry_next;
    logic [BW-1:0]                cur_a_reg, cur_a_next;
    logic [BW-1:0]                cur_b_reg, cur_b_next;
    logic [cfl_pkg::LFSR_W-1:0]   lfsr_reg, lfsr_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [cfl_pkg::MIX_W-1:0]    mix_reg, mix_next;
    logic [BW-1:0]                pb_reg, pb_next;
    logic [cfl_pkg::KICKS_W-1:0]  kicks_reg, kicks_next;
    logic                         m_valid_reg, m_valid_next;
    cfl_pkg::status_t             status_reg, status_next;
    logic [cfl_pkg::KICKS_W-1:0]  kout_reg, kout_next;

    logic                         ram_we;
    logic [BW-1:0]                ram_waddr;
    logic [ROW_W-1:0]             ram_wdata;
    logic                         ram_re;
    logic [BW-1:0]                ram_raddr_a;
    logic [BW-1:0]                ram_raddr_b;
    logic [ROW_W-1:0]             rd_a;
    logic [ROW_W-1:0]             rd_b;

    cfl_pkg::kind_t               q_kind;
    logic [FP_BITS-1:0]           q_fp;
    logic [BW-1:0]                q_b1;
    logic [BW-1:0]                q_b2;

    logic                         out_free;
    logic                         hit;
    logic [CAND_W-1:0]            cand;
    logic                         place_found;
    logic                         place_sel_b;
    logic [SLOT_W-1:0]            place_slot;
    logic [ROW_W-1:0]             place_row;
    logic [BW-1:0]                place_addr;
    logic [ROW_W-1:0]             pick_row;
    logic [BW-1:0]                kick_pb;
    logic [FP_BITS-1:0]           kick_evicted;
    logic [ROW_W-1:0]             kick_row;
    logic [cfl_pkg::LFSR_W-1:0]   lfsr_adv;
    logic [DIFF_W-1:0]            slot_diff;
    logic [cfl_pkg::MIX_W-1:0]    alt_full;

    assign q_kind             = cfl_pkg::kind_t'(q_item[ITEM_W-1 -: 2]);
    assign {q_fp, q_b1, q_b2} = q_item[ITEM_W-3:0];

    assign out_free     = !m_valid_reg || m_ready;
    assign clearing     = (state_reg == cfl_pkg::BK_CLEAR);
    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_kicks_used = kout_reg;

    // bucket table, one row per bucket
    cfl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_table (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .re_b    (ram_re),
        .raddr_b (ram_raddr_b),
        .rdata_b (rd_b)
    );

    // lookup match over both buckets
    always_comb begin
        hit = 1'b0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (rd_a[s*FP_BITS +: FP_BITS] == carry_reg ||
                rd_b[s*FP_BITS +: FP_BITS] == carry_reg) begin
                hit = 1'b1;
            end
        end
    end

    // first free slot, primary and alternate interleaved
    always_comb begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            cand[2*s]   = (rd_a[s*FP_BITS +: FP_BITS] == '0);
            cand[2*s+1] = (rd_b[s*FP_BITS +: FP_BITS] == '0);
        end
        place_found = 1'b0;
        place_sel_b = 1'b0;
        place_slot  = '0;
        for (int i = CAND_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                place_found = 1'b1;
                place_sel_b = 1'(i & 1);
                place_slot  = SLOT_W'(i >> 1);
            end
        end
        place_row = place_sel_b ? rd_b : rd_a;
        place_row[int'(place_slot)*FP_BITS +: FP_BITS] = carry_reg;
        place_addr = place_sel_b ? cur_b_reg : cur_a_reg;
    end

    // eviction swap in the lfsr-chosen bucket and slot
    always_comb begin
        pick_row     = lfsr_reg[0] ? rd_b : rd_a;
        kick_pb      = lfsr_reg[0] ? cur_b_reg : cur_a_reg;
        kick_evicted = pick_row[int'(slot_reg)*FP_BITS +: FP_BITS];
        kick_row     = pick_row;
        kick_row[int'(slot_reg)*FP_BITS +: FP_BITS] = carry_reg;
    end

    // lfsr step, slot remainder and alternate of the evicted entry
    always_comb begin
        lfsr_adv  = cfl_pkg::lfsr_step(lfsr_reg);
        slot_diff = DIFF_W'(lfsr_reg[cfl_pkg::LFSR_W-1:1])
                  - DIFF_W'(prod_reg[RECIP_SH +: X_W]) * DIFF_W'(SLOTS_PER_BUCKET);
        alt_full  = cfl_pkg::bucket_mask(cfl_pkg::MIX_W'(pb_reg) ^ mix_reg, bucket_bits);
    end

    // sequencer: next state, table access and result
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        kind_next    = kind_reg;
        carry_next   = carry_reg;
        cur_a_next   = cur_a_reg;
        cur_b_next   = cur_b_reg;
        lfsr_next    = lfsr_reg;
        prod_next    = prod_reg;
        slot_next    = slot_reg;
        mix_next     = mix_reg;
        pb_next      = pb_reg;
        kicks_next   = kicks_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        kout_next    = kout_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = place_addr;
        ram_wdata    = place_row;
        ram_re       = 1'b0;
        ram_raddr_a  = cur_a_reg;
        ram_raddr_b  = cur_b_reg;

        unique case (state_reg)
            cfl_pkg::BK_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + BW'(1);
                if (clr_cnt_reg == BW'(NUM_BUCKETS - 1)) begin
                    state_next = cfl_pkg::BK_IDLE;
                end
            end
            cfl_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    ram_re      = 1'b1;
                    ram_raddr_a = q_b1;
                    ram_raddr_b = q_b2;
                    kind_next   = q_kind;
                    carry_next  = q_fp;
                    cur_a_next  = q_b1;
                    cur_b_next  = q_b2;
                    kicks_next  = '0;
                    state_next  = cfl_pkg::BK_EVAL;
                end
            end
            cfl_pkg::BK_EVAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kout_next    = '0;
                    state_next   = cfl_pkg::BK_IDLE;
                    unique case (kind_reg)
                        cfl_pkg::KIND_LOOKUP: begin
                            status_next = hit ? cfl_pkg::STS_PRESENT : cfl_pkg::STS_ABSENT;
                        end
                        cfl_pkg::KIND_ZERO_LOOKUP: begin
                            status_next = cfl_pkg::STS_ABSENT;
                        end
                        cfl_pkg::KIND_ZERO_INSERT: begin
                            status_next = cfl_pkg::STS_FAILED;
                        end
                        cfl_pkg::KIND_INSERT: begin
                            if (place_found) begin
                                ram_we      = 1'b1;
                                status_next = cfl_pkg::STS_STORED;
                            end else if (max_kicks == '0) begin
                                status_next = cfl_pkg::STS_FAILED;
                            end else begin
                                m_valid_next = m_valid_reg && !m_ready;
                                state_next   = cfl_pkg::BK_ADV;
                            end
                        end
                    endcase
                end
            end
            cfl_pkg::BK_ADV: begin
                lfsr_next  = lfsr_adv;
                prod_next  = PROD_W'(lfsr_adv[cfl_pkg::LFSR_W-1:1]) * PROD_W'(RECIP);
                state_next = cfl_pkg::BK_SEL;
            end
            cfl_pkg::BK_SEL: begin
                slot_next  = slot_diff[SLOT_W-1:0];
                state_next = cfl_pkg::BK_KICK;
            end
            cfl_pkg::BK_KICK: begin
                ram_we     = 1'b1;
                ram_waddr  = kick_pb;
                ram_wdata  = kick_row;
                carry_next = kick_evicted;
                mix_next   = cfl_pkg::fp_mix(cfl_pkg::MIX_W'(kick_evicted));
                pb_next    = kick_pb;
                kicks_next = kicks_reg + cfl_pkg::KICKS_W'(1);
                state_next = cfl_pkg::BK_ALT;
            end
            cfl_pkg::BK_ALT: begin
                ram_re      = 1'b1;
                ram_raddr_a = alt_full[BW-1:0];
                ram_raddr_b = alt_full[BW-1:0];
                cur_a_next  = alt_full[BW-1:0];
                cur_b_next  = alt_full[BW-1:0];
                state_next  = cfl_pkg::BK_PLACE;
            end
            cfl_pkg::BK_PLACE: begin
                if (out_free) begin
                    if (place_found) begin
                        ram_we       = 1'b1;
                        m_valid_next = 1'b1;
                        status_next  = cfl_pkg::STS_STORED;
                        kout_next    = kicks_reg;
                        state_next   = cfl_pkg::BK_IDLE;
                    end else if (kicks_reg < max_kicks) begin
                        state_next = cfl_pkg::BK_ADV;
                    end else begin
                        m_valid_next = 1'b1;
                        status_next  = cfl_pkg::STS_FAILED;
                        kout_next    = kicks_reg;
                        state_next   = cfl_pkg::BK_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cfl_pkg::BK_CLEAR;
            clr_cnt_reg <= '0;
            lfsr_reg    <= cfl_pkg::LFSR_SEED;
            kicks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            lfsr_reg    <= lfsr_next;
            kicks_reg   <= kicks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        carry_reg  <= carry_next;
        cur_a_reg  <= cur_a_next;
        cur_b_reg  <= cur_b_next;
        prod_reg   <= prod_next;
        slot_reg   <= slot_next;
        mix_reg    <= mix_next;
        pb_reg     <= pb_next;
        status_reg <= status_next;
        kout_reg   <= kout_next;
    end

    `CFL_ASSERT_IMP(a_lfsr_nonzero, aclk, aresetn, 1'b1, lfsr_reg != '0,
                    "lfsr reached zero")
    `CFL_ASSERT_IMP(a_no_result_in_clear, aclk, aresetn,
                    state_reg == cfl_pkg::BK_CLEAR, !m_valid_reg,
                    "result raised during table clear")
    `CFL_ASSERT_IMP(a_result_source, aclk, aresetn, $rose(m_valid_reg),
                    $past(state_reg == cfl_pkg::BK_EVAL || state_reg == cfl_pkg::BK_PLACE),
                    "result raised outside eval or place")
    `CFL_ASSERT_NXT(a_pop_reads, aclk, aresetn, q_pop,
                    state_reg == cfl_pkg::BK_EVAL && !clearing,
                    "pop not followed by bucket evaluation")

endmodule
